// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EOTT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EOTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/eott_pkg.sv =====
package eott_pkg;

	localparam int SLOTS        = 32;
	localparam int SLOT_W       = $clog2(SLOTS);
	localparam int CNT_W        = $clog2(SLOTS + 1);
	localparam int RESULT_CAP   = 32;
	localparam int RES_W        = $clog2(RESULT_CAP);
	localparam int TIME_W       = 32;
	localparam int INC_W        = 16;
	localparam int ACTION_W     = 2;
	localparam int SLOT_FIELD_W = 5;
	localparam int STATUS_W     = 2;

	localparam logic [ACTION_W-1:0] ACT_ADD     = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REFRESH = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ACTIVE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PUT
	} state_t;

endpackage

// ===== hdl/eott_if.sv =====
interface eott_cmd_if;
	import eott_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ACTION_W-1:0]     action;
	logic [SLOT_FIELD_W-1:0] slot;
	logic [TIME_W-1:0]       time_value;
	logic [INC_W-1:0]        increment;

	modport source (output valid, output action, output slot, output time_value,
		output increment, input ready);
	modport sink (input valid, input action, input slot, input time_value,
		input increment, output ready);
endinterface

interface eott_rsp_if;
	import eott_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic                    expired_valid;
	logic [SLOT_FIELD_W-1:0] expired_slot;
	logic                    last;

	modport source (output valid, output status, output expired_valid,
		output expired_slot, output last, input ready);
	modport sink (input valid, input status, input expired_valid,
		input expired_slot, input last, output ready);
endinterface

// ===== hdl/expiry_ordered_timer_table.sv =====
// Channel  Direction  Payload
// cmd      in         action, slot, time_value, increment
// rsp      out        status, expired_valid, expired_slot, last
//
// Add, refresh and remove update the table on acceptance; the response is held in the result
// register and moved to the output register once that register is free.
// A tick with k expiries returns max(k, 1) responses, and each response costs one full
// pass over the expiry memory.
// Reset clears the active marks at once; the expiry memory needs no clearing.
// A new transaction is taken while the last response still waits in the output register;
// a stalled output holds the sequencer only when a further response is due.
module expiry_ordered_timer_table (
	input  logic       clk,
	input  logic       arst_n,
	eott_cmd_if.sink   cmd,
	eott_rsp_if.source rsp
);
	import eott_pkg::*;

	state_t state_q, state_d;

	logic [TIME_W-1:0] mem_q [SLOTS];
	logic [TIME_W-1:0] rd_data_s1;
	logic              vld_s1;
	logic [SLOT_W-1:0] idx_s1;

	logic [SLOTS-1:0]  active_q;
	logic [TIME_W-1:0] now_q;
	logic [SLOT_W-1:0] idx_q;
	logic              iss_q;
	logic              found_q;
	logic [SLOT_W-1:0] best_q;
	logic [TIME_W-1:0] best_time_q;
	logic [CNT_W-1:0]  cand_q;
	logic [RES_W-1:0]  cnt_q;

	logic [STATUS_W-1:0] res_status_q;
	logic                res_exp_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic                res_last_q;

	logic                    out_valid_q;
	logic [STATUS_W-1:0]     out_status_q;
	logic                    out_exp_q;
	logic [SLOT_FIELD_W-1:0] out_slot_q;
	logic                    out_last_q;

	logic              cmd_fire;
	logic              out_free;
	logic              in_range;
	logic [SLOT_W-1:0] slot_idx;
	logic              slot_act;
	logic [TIME_W:0]   sum_wide;
	logic [TIME_W-1:0] sum_sat;
	logic              mem_we;
	logic [TIME_W-1:0] mem_wdata;
	logic              cand_hit;
	logic              better;
	logic              scan_done;
	logic              fin_found;
	logic [SLOT_W-1:0] fin_best;
	logic [CNT_W-1:0]  fin_cand;
	logic              scan_start;
	logic              put_load;
	logic [STATUS_W-1:0] cmd_status;

	assign cmd.ready     = (state_q == S_IDLE);
	assign cmd_fire      = cmd.valid && cmd.ready;
	assign out_free      = !out_valid_q || rsp.ready;
	assign in_range      = 32'(cmd.slot) < 32'(SLOTS);
	assign slot_idx      = SLOT_W'(cmd.slot);
	assign slot_act      = in_range && active_q[slot_idx];
	assign sum_wide      = {1'b0, cmd.time_value} + (TIME_W + 1)'(cmd.increment);
	assign sum_sat       = sum_wide[TIME_W] ? {TIME_W{1'b1}} : sum_wide[TIME_W-1:0];

	assign cand_hit  = vld_s1 && active_q[idx_s1] && (rd_data_s1 <= now_q);
	assign better    = cand_hit && (!found_q || (rd_data_s1 < best_time_q));
	assign scan_done = vld_s1 && (idx_s1 == SLOT_W'(SLOTS - 1));
	assign fin_found = found_q || cand_hit;
	assign fin_best  = better ? idx_s1 : best_q;
	assign fin_cand  = cand_q + CNT_W'(cand_hit);

	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_wdata  = cmd.time_value;
		scan_start = 1'b0;
		put_load   = 1'b0;
		cmd_status = ST_OK;
		if (cmd.action == ACT_ADD) begin
			if (!in_range) begin
				cmd_status = ST_INACTIVE;
			end else if (slot_act) begin
				cmd_status = ST_ACTIVE;
			end
		end else if (!slot_act) begin
			cmd_status = ST_INACTIVE;
		end
		case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					if (cmd.action == ACT_TICK) begin
						scan_start = 1'b1;
						state_d    = S_SCAN;
					end else begin
						state_d = S_PUT;
						if (cmd.action == ACT_ADD && cmd_status == ST_OK) begin
							mem_we = 1'b1;
						end
						if (cmd.action == ACT_REFRESH && slot_act) begin
							mem_we    = 1'b1;
							mem_wdata = sum_sat;
						end
					end
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				if (out_free) begin
					put_load = 1'b1;
					if (res_last_q) begin
						state_d = S_IDLE;
					end else begin
						scan_start = 1'b1;
						state_d    = S_SCAN;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[slot_idx] <= mem_wdata;
		end
		rd_data_s1 <= mem_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= '0;
			iss_q       <= 1'b0;
			vld_s1      <= 1'b0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			cand_q      <= '0;
			cnt_q       <= '0;
			res_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= iss_q;
			if (scan_start) begin
				iss_q   <= 1'b1;
				idx_q   <= '0;
				found_q <= 1'b0;
				cand_q  <= '0;
			end else if (iss_q) begin
				idx_q <= idx_q + SLOT_W'(1);
				if (idx_q == SLOT_W'(SLOTS - 1)) begin
					iss_q <= 1'b0;
				end
			end
			if (vld_s1 && !scan_done) begin
				found_q <= fin_found;
				cand_q  <= fin_cand;
			end
			if (cmd_fire) begin
				if (cmd.action == ACT_TICK) begin
					cnt_q <= '0;
				end else begin
					res_last_q <= 1'b1;
					if (cmd.action == ACT_ADD && cmd_status == ST_OK) begin
						active_q[slot_idx] <= 1'b1;
					end
					if (cmd.action == ACT_REMOVE && slot_act) begin
						active_q[slot_idx] <= 1'b0;
					end
				end
			end
			if (scan_done) begin
				res_last_q <= !fin_found || (fin_cand == CNT_W'(1)) ||
					(cnt_q == RES_W'(RESULT_CAP - 1));
				if (fin_found) begin
					active_q[fin_best] <= 1'b0;
				end
			end
			if (put_load) begin
				out_valid_q <= 1'b1;
				if (!res_last_q) begin
					cnt_q <= cnt_q + RES_W'(1);
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (scan_start) begin
			now_q <= (state_q == S_IDLE) ? cmd.time_value : now_q;
		end
		if (better && !scan_done) begin
			best_q      <= idx_s1;
			best_time_q <= rd_data_s1;
		end
		if (cmd_fire && cmd.action != ACT_TICK) begin
			res_status_q <= cmd_status;
			res_exp_q    <= 1'b0;
			res_slot_q   <= '0;
		end
		if (scan_done) begin
			res_status_q <= ST_OK;
			res_exp_q    <= fin_found;
			res_slot_q   <= fin_found ? fin_best : '0;
		end
		if (put_load) begin
			out_status_q <= res_status_q;
			out_exp_q    <= res_exp_q;
			out_slot_q   <= SLOT_FIELD_W'(res_slot_q);
			out_last_q   <= res_last_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.expired_valid = out_exp_q;
	assign rsp.expired_slot  = out_slot_q;
	assign rsp.last          = out_last_q;

endmodule

// ===== hdl/eott_checker.sv =====
`include "assert_macros.svh"

module eott_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cmd_valid,
	input logic                              cmd_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [eott_pkg::STATUS_W-1:0]     rsp_status,
	input logic                              rsp_expired_valid,
	input logic [eott_pkg::SLOT_FIELD_W-1:0] rsp_expired_slot,
	input logic                              rsp_last
);
	import eott_pkg::*;

	// A stalled response must not change until it is taken.
	`EOTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_expired_valid) && $stable(rsp_expired_slot) && $stable(rsp_last), "response changed while stalled")
	// Every transaction keeps the sequencer busy, so no new transaction is taken straight after it.
	`EOTT_ASSERT_NEXT(a_cmd_busy, cmd_valid && cmd_ready, !cmd_ready, "transaction taken in consecutive cycles")
	// While a tick still owes responses, no new transaction may be taken.
	`EOTT_ASSERT_SAME(a_tick_open, rsp_valid && rsp_ready && !rsp_last, !cmd_ready, "transaction taken before the final response")
	// An expiry report always carries an ok status.
	`EOTT_ASSERT_SAME(a_expiry_ok, rsp_valid && rsp_expired_valid, rsp_status == ST_OK, "expiry reported with an error status")

endmodule

bind expiry_ordered_timer_table eott_checker u_eott_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cmd_valid         (cmd.valid),
	.cmd_ready         (cmd.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_expired_valid (rsp.expired_valid),
	.rsp_expired_slot  (rsp.expired_slot),
	.rsp_last          (rsp.last)
);

// ===== sim/eott_monitor.sv =====
`timescale 1ns / 1ps

module eott_monitor
	import eott_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	eott_cmd_if  cmd,
	eott_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic                    expired_valid;
		logic [SLOT_FIELD_W-1:0] expired_slot;
		logic                    last;
	} timer_rsp_t;

	timer_rsp_t        due_rsps[$];
	logic [TIME_W-1:0] expiry_time[SLOTS];
	bit                armed[SLOTS];

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic void push_rsp(input logic [STATUS_W-1:0] status, input logic ev,
		input logic [SLOT_FIELD_W-1:0] s, input logic last);
		timer_rsp_t r;
		r = '{status, ev, s, last};
		due_rsps.push_back(r);
	endfunction

	function automatic void predict_cmd(input logic [ACTION_W-1:0] action,
		input logic [SLOT_FIELD_W-1:0] slot, input logic [TIME_W-1:0] tv,
		input logic [INC_W-1:0] inc);
		int         best;
		int         count;
		bit         in_range;
		bit         is_armed;
		logic [TIME_W:0] sum;
		timer_rsp_t r;
		in_range = int'(slot) < SLOTS;
		is_armed = in_range && armed[slot];
		count = 0;
		case (action)
			ACT_TICK: begin
				for (int n = 0; n < RESULT_CAP; n++) begin
					best = -1;
					for (int i = 0; i < SLOTS; i++) begin
						if (armed[i] && expiry_time[i] <= tv &&
							(best < 0 || expiry_time[i] < expiry_time[best])) begin
							best = i;
						end
					end
					if (best < 0) begin
						break;
					end
					armed[best] = 1'b0;
					push_rsp(ST_OK, 1'b1, SLOT_FIELD_W'(best), 1'b0);
					count++;
				end
				if (count == 0) begin
					push_rsp(ST_OK, 1'b0, '0, 1'b1);
				end else begin
					r = due_rsps.pop_back();
					r.last = 1'b1;
					due_rsps.push_back(r);
				end
			end
			ACT_ADD: begin
				if (!in_range) begin
					push_rsp(ST_INACTIVE, 1'b0, '0, 1'b1);
				end else if (is_armed) begin
					push_rsp(ST_ACTIVE, 1'b0, '0, 1'b1);
				end else begin
					expiry_time[slot] = tv;
					armed[slot] = 1'b1;
					push_rsp(ST_OK, 1'b0, '0, 1'b1);
				end
			end
			default: begin
				if (!is_armed) begin
					push_rsp(ST_INACTIVE, 1'b0, '0, 1'b1);
				end else begin
					if (action == ACT_REFRESH) begin
						sum = {1'b0, tv} + {{(TIME_W + 1 - INC_W){1'b0}}, inc};
						expiry_time[slot] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
					end else begin
						armed[slot] = 1'b0;
					end
					push_rsp(ST_OK, 1'b0, '0, 1'b1);
				end
			end
		endcase
	endfunction

	task automatic check_rsp();
		timer_rsp_t got;
		timer_rsp_t want;
		got = '{rsp.status, rsp.expired_valid, rsp.expired_slot, rsp.last};
		if (due_rsps.size() == 0) begin
			report_mismatch($sformatf("unexpected transaction %p", got));
		end else begin
			want = due_rsps.pop_front();
			if (got.status !== want.status || got.expired_valid !== want.expired_valid ||
				got.expired_slot !== want.expired_slot || got.last !== want.last) begin
				report_mismatch($sformatf("got %p, expected %p", got, want));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_rsps.delete();
			for (int i = 0; i < SLOTS; i++) begin
				armed[i] = 1'b0;
			end
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				predict_cmd(cmd.action, cmd.slot, cmd.time_value, cmd.increment);
			end
			if (rsp.valid && rsp.ready) begin
				check_rsp();
			end
			pending <= due_rsps.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import eott_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;

	logic              clk;
	logic              arst_n;
	int                idle_pct = 0;
	int                stall_pct = 0;
	int                fail_count;
	int                pending;
	int                cycles = 0;
	logic [TIME_W-1:0] now;

	eott_cmd_if cmd_ch ();
	eott_rsp_if rsp_ch ();

	expiry_ordered_timer_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	eott_monitor monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= $urandom_range(99) >= stall_pct;
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_cmd(input logic [ACTION_W-1:0] action,
		input logic [SLOT_FIELD_W-1:0] slot, input logic [TIME_W-1:0] tv,
		input logic [INC_W-1:0] inc);
		while ($urandom_range(99) < idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.action     <= action;
		cmd_ch.slot       <= slot;
		cmd_ch.time_value <= tv;
		cmd_ch.increment  <= inc;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic run_directed();
		send_cmd(ACT_TICK, 5'd0, 32'd0, 16'd0);
		send_cmd(ACT_ADD, 5'd0, 32'd0, 16'd0);
		send_cmd(ACT_TICK, 5'd31, 32'd0, 16'hFFFF);
		send_cmd(ACT_ADD, 5'd0, 32'd0, 16'd0);
		send_cmd(ACT_ADD, 5'd0, 32'd5, 16'd0);
		send_cmd(ACT_ADD, 5'd31, 32'hFFFF_FFFF, 16'd0);
		send_cmd(ACT_REFRESH, 5'd5, 32'd7, 16'd3);
		send_cmd(ACT_REMOVE, 5'd6, 32'd0, 16'd0);
		send_cmd(ACT_REFRESH, 5'd0, 32'hFFFF_FFF0, 16'hFFFF);
		send_cmd(ACT_ADD, 5'd3, 32'd100, 16'd0);
		send_cmd(ACT_ADD, 5'd4, 32'd100, 16'd0);
		send_cmd(ACT_ADD, 5'd2, 32'd50, 16'd0);
		send_cmd(ACT_ADD, 5'd7, 32'd30, 16'd0);
		send_cmd(ACT_REFRESH, 5'd31, 32'd10, 16'd0);
		send_cmd(ACT_REFRESH, 5'd7, 32'd60, 16'd20);
		send_cmd(ACT_TICK, 5'd0, 32'd99, 16'd0);
		send_cmd(ACT_TICK, 5'd0, 32'd100, 16'd0);
		send_cmd(ACT_REMOVE, 5'd0, 32'd0, 16'd0);
		send_cmd(ACT_REMOVE, 5'd0, 32'd0, 16'd0);
		send_cmd(ACT_TICK, 5'd0, 32'hFFFF_FFFF, 16'd0);
		send_cmd(ACT_ADD, 5'd21, 32'hAAAA_AAAA, 16'h5555);
		send_cmd(ACT_ADD, 5'd10, 32'h5555_5555, 16'hAAAA);
		send_cmd(ACT_TICK, 5'd0, 32'hFFFF_FFFF, 16'd0);
	endtask

	task automatic run_random(input int n, input bit with_burst);
		int pick;
		logic [INC_W-1:0] inc;
		if (with_burst) begin
			send_cmd(ACT_TICK, SLOT_FIELD_W'($urandom), '1, INC_W'($urandom));
			for (int s = 0; s < SLOTS; s++) begin
				send_cmd(ACT_ADD, SLOT_FIELD_W'(s), now + $urandom_range(0, 8), INC_W'($urandom));
			end
			now += 10;
			send_cmd(ACT_TICK, SLOT_FIELD_W'($urandom), now, INC_W'($urandom));
		end
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				send_cmd(ACTION_W'($urandom), SLOT_FIELD_W'($urandom), $urandom,
					INC_W'($urandom));
			end else if (pick < 44) begin
				send_cmd(ACT_ADD, SLOT_FIELD_W'($urandom), now + $urandom_range(0, 60),
					INC_W'($urandom));
			end else if (pick < 62) begin
				inc = ($urandom_range(9) == 0) ? INC_W'($urandom) : INC_W'($urandom_range(0, 60));
				send_cmd(ACT_REFRESH, SLOT_FIELD_W'($urandom), now, inc);
			end else if (pick < 75) begin
				send_cmd(ACT_REMOVE, SLOT_FIELD_W'($urandom), $urandom, INC_W'($urandom));
			end else begin
				now += $urandom_range(0, 15);
				send_cmd(ACT_TICK, SLOT_FIELD_W'($urandom), now, INC_W'($urandom));
			end
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.action     <= ACT_TICK;
		cmd_ch.slot       <= '0;
		cmd_ch.time_value <= '0;
		cmd_ch.increment  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_drained();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
					now = $urandom_range(0, 1000);
				end
				1: begin
					idle_pct = 58;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 58;
					now = 32'hFFFF_F000;
				end
				default: begin
					idle_pct = 30;
					stall_pct = 30;
				end
			endcase
			run_random(90, phase == 0 || phase == 3);
			wait_drained();
		end
		repeat (4 * (SLOTS + 2)) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/eott_pkg.sv
hdl/eott_if.sv
hdl/expiry_ordered_timer_table.sv
hdl/eott_checker.sv
sim/eott_monitor.sv
sim/tb.sv
